// ===== rtl/imu_fgp_pkg.sv =====
// shared types and constants for the imu frame group parser
`default_nettype none

package imu_fgp_pkg;

   localparam int FramesPerGroupDefault = 3;

   localparam logic [7:0] HeaderByteReset = 8'h55;
   localparam logic [7:0] TypeAccel = 8'h51;
   localparam logic [7:0] TypeGyro = 8'h52;
   localparam logic [7:0] TypeAngle = 8'h53;

   // byte positions inside one frame
   localparam logic [3:0] PosHeader = 4'd0;
   localparam logic [3:0] PosType = 4'd1;
   localparam logic [3:0] PosPayloadFirst = 4'd2;
   localparam logic [3:0] PosPayloadLast = 4'd7;
   localparam logic [3:0] PosCheck = 4'd10;

   localparam int PayloadBytes = 6;
   localparam int SampleWords = 9;

   // word slots in the held sample set
   localparam int IdxAccelX = 0;
   localparam int IdxAccelY = 1;
   localparam int IdxAccelZ = 2;
   localparam int IdxGyroX = 3;
   localparam int IdxGyroY = 4;
   localparam int IdxGyroZ = 5;
   localparam int IdxRoll = 6;
   localparam int IdxPitch = 7;
   localparam int IdxYaw = 8;

   // register map
   localparam int CsrAddrWidth = 3;
   localparam logic [0:0] RegHeaderByte = 1'b0;

   typedef enum logic [1:0] {
      STATUS_GOOD = 2'd0,
      STATUS_INCOMPLETE = 2'd1,
      STATUS_LOST = 2'd2
   } status_type;

   typedef struct packed {
      logic [SampleWords-1:0][15:0] samples;
      status_type status;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/imu_fgp_csr.sv =====
// register port holding the frame header byte
`default_nettype none

module imu_fgp_csr
   import imu_fgp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready,
   output logic [7:0]                   header_byte
);

   logic [7:0] header_ff;
   logic [7:0] header_in;
   logic       wr_en;
   logic       hit;

   assign csr_pready = 1'b1;
   assign hit = (csr_paddr[CsrAddrWidth-1:2] == RegHeaderByte);
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready && hit;

   always_comb begin
      header_in = header_ff;
      if (wr_en) begin
         header_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HeaderByteReset;
      end else begin
         header_ff <= header_in;
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (hit) begin
         csr_prdata = {24'd0, header_ff};
      end
   end

   assign header_byte = header_ff;

endmodule

`default_nettype wire

// ===== rtl/imu_fgp_core.sv =====
// input register, frame parsing state, held samples and result register
`default_nettype none

module imu_fgp_core
   import imu_fgp_pkg::*;
#(
   parameter int FRAMES_PER_GROUP = FramesPerGroupDefault
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] header_byte,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output result_type      rsp_result
);

   localparam logic [1:0] GroupLen = 2'(FRAMES_PER_GROUP);

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] byte_ff;
   logic       advance;

   // parsing state
   logic                           hunting_ff, hunting_in;
   logic [3:0]                     pos_ff, pos_in;
   logic [1:0]                     frame_ff, frame_in;
   logic [7:0]                     sum_ff, sum_in;
   logic [7:0]                     type_ff, type_in;
   logic [PayloadBytes-1:0][7:0]   payload_ff, payload_in;
   logic [1:0]                     good_ff, good_in;
   logic [SampleWords-1:0][15:0]   held_ff, held_in;
   logic [2:0]                     pay_idx;
   logic [2:0][15:0]               words;
   logic                           check_ok;

   // result
   logic       res_emit;
   status_type res_status;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff;

   assign advance = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_data_byte;
      end
   end

   assign pay_idx = 3'(pos_ff - PosPayloadFirst);
   assign check_ok = (sum_ff == byte_ff);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         words[i] = {payload_ff[2*i+1], payload_ff[2*i]};
      end
   end

   always_comb begin
      hunting_in = hunting_ff;
      pos_in = pos_ff;
      frame_in = frame_ff;
      sum_in = sum_ff;
      type_in = type_ff;
      payload_in = payload_ff;
      good_in = good_ff;
      held_in = held_ff;
      res_emit = 1'b0;
      res_status = STATUS_GOOD;
      if (hunting_ff) begin
         if (byte_ff == header_byte) begin
            hunting_in = 1'b0;
            pos_in = PosType;
            frame_in = 2'd0;
            sum_in = byte_ff;
            good_in = 2'd0;
         end
      end else if (pos_ff == PosHeader) begin
         if (byte_ff != header_byte) begin
            hunting_in = 1'b1;
            res_emit = 1'b1;
            res_status = STATUS_LOST;
         end else begin
            sum_in = byte_ff;
            pos_in = PosType;
         end
      end else if (pos_ff < PosCheck) begin
         if (pos_ff == PosType) begin
            type_in = byte_ff;
         end else if (pos_ff <= PosPayloadLast) begin
            payload_in[pay_idx] = byte_ff;
         end
         sum_in = sum_ff + byte_ff;
         pos_in = pos_ff + 4'd1;
      end else begin
         // checksum byte closes the frame
         case (type_ff)
            TypeAccel: begin
               if (check_ok) begin
                  held_in[IdxAccelX] = words[0];
                  held_in[IdxAccelY] = words[1];
                  held_in[IdxAccelZ] = words[2];
                  good_in = good_ff + 2'd1;
               end
            end
            TypeGyro: begin
               if (check_ok) begin
                  held_in[IdxGyroX] = words[0];
                  held_in[IdxGyroY] = words[1];
                  held_in[IdxGyroZ] = words[2];
                  good_in = good_ff + 2'd1;
               end
            end
            TypeAngle: begin
               if (check_ok) begin
                  held_in[IdxRoll] = words[0];
                  held_in[IdxPitch] = words[1];
                  held_in[IdxYaw] = words[2];
                  good_in = good_ff + 2'd1;
               end
            end
            default: begin
               good_in = 2'd0;
            end
         endcase
         pos_in = PosHeader;
         frame_in = frame_ff + 2'd1;
         if (frame_in >= GroupLen) begin
            hunting_in = 1'b1;
            frame_in = 2'd0;
            res_emit = 1'b1;
            res_status = (good_in == GroupLen) ? STATUS_GOOD : STATUS_INCOMPLETE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunting_ff <= 1'b1;
         pos_ff <= PosHeader;
         frame_ff <= 2'd0;
         sum_ff <= 8'd0;
         type_ff <= 8'd0;
         good_ff <= 2'd0;
         held_ff <= '0;
      end else if (advance) begin
         hunting_ff <= hunting_in;
         pos_ff <= pos_in;
         frame_ff <= frame_in;
         sum_ff <= sum_in;
         type_ff <= type_in;
         good_ff <= good_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         payload_ff <= payload_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && res_emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_emit) begin
         rsp_result_ff.samples <= held_in;
         rsp_result_ff.status <= res_status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      hunting_ff |-> !res_emit)
      else $error("result raised while hunting");

   assert property (@(posedge clock) disable iff (reset)
      !hunting_ff |-> (pos_ff <= PosCheck && frame_ff < GroupLen))
      else $error("frame position out of range");

   assert property (@(posedge clock) disable iff (reset)
      good_ff <= GroupLen)
      else $error("good count exceeds group length");

   assert property (@(posedge clock) disable iff (reset)
      (advance && res_emit) |=> rsp_valid_ff)
      else $error("emitted result not registered");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(advance && !hunting_ff && pos_ff == PosCheck))
      else $error("frame closed while result register blocked");
`endif

endmodule

`default_nettype wire

// ===== rtl/imu_frame_group_parser.sv =====
// top level of the imu frame group parser
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data_byte
//   rsp      out        rsp_valid/rsp_stall  nine held sample words, rsp_group_status
//   csr      in         apb style            header byte at address 0
//
// one byte per cycle while req is not stalled; a byte passes the input register and the
// parsing logic, and the byte that closes a group or loses the header loads the result register.
// reset returns to hunting with all held samples zero and header byte 0x55.
// a stalled result register holds the parsing stage, which then stalls req.
// FRAMES_PER_GROUP ranges from 1 to 3.
`default_nettype none

module imu_frame_group_parser
   import imu_fgp_pkg::*;
#(
   parameter int FRAMES_PER_GROUP = FramesPerGroupDefault
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [7:0]              req_data_byte,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [15:0]           rsp_accel_x,
   output logic signed [15:0]           rsp_accel_y,
   output logic signed [15:0]           rsp_accel_z,
   output logic signed [15:0]           rsp_gyro_x,
   output logic signed [15:0]           rsp_gyro_y,
   output logic signed [15:0]           rsp_gyro_z,
   output logic signed [15:0]           rsp_roll_angle,
   output logic signed [15:0]           rsp_pitch_angle,
   output logic signed [15:0]           rsp_yaw_angle,
   output logic [1:0]                   rsp_group_status,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   logic [7:0] header_byte;
   result_type result;

   imu_fgp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .header_byte (header_byte)
   );

   imu_fgp_core #(
      .FRAMES_PER_GROUP (FRAMES_PER_GROUP)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .header_byte   (header_byte),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result    (result)
   );

   assign rsp_accel_x = signed'(result.samples[IdxAccelX]);
   assign rsp_accel_y = signed'(result.samples[IdxAccelY]);
   assign rsp_accel_z = signed'(result.samples[IdxAccelZ]);
   assign rsp_gyro_x = signed'(result.samples[IdxGyroX]);
   assign rsp_gyro_y = signed'(result.samples[IdxGyroY]);
   assign rsp_gyro_z = signed'(result.samples[IdxGyroZ]);
   assign rsp_roll_angle = signed'(result.samples[IdxRoll]);
   assign rsp_pitch_angle = signed'(result.samples[IdxPitch]);
   assign rsp_yaw_angle = signed'(result.samples[IdxYaw]);
   assign rsp_group_status = result.status;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the imu frame group parser: random byte streams checked against a group tracker
`default_nettype none

module tb;
   import imu_fgp_pkg::*;

   class imu_group_tracker;
      logic [7:0] header = HeaderByteReset;
      bit hunting = 1'b1;
      logic [3:0] position = PosHeader;
      logic [1:0] frame_no = 2'd0;
      logic [7:0] sum = 8'h00;
      logic [7:0] frame_kind = 8'h00;
      logic [7:0] payload [PayloadBytes] = '{default: 8'h00};
      logic [1:0] good = 2'd0;
      logic [15:0] held [SampleWords] = '{default: 16'h0000};
      result_type expected_groups [$];
      int errors = 0;

      function void publish(status_type status);
         result_type r;
         for (int i = 0; i < SampleWords; i++) r.samples[i] = held[i];
         r.status = status;
         expected_groups.push_back(r);
      endfunction

      function void note_byte(logic [7:0] b);
         int base;
         if (hunting) begin
            if (b == header) begin
               hunting = 1'b0;
               position = PosType;
               frame_no = 2'd0;
               sum = b;
               good = 2'd0;
            end
            return;
         end
         if (position == PosHeader) begin
            if (b != header) begin
               hunting = 1'b1;
               publish(STATUS_LOST);
            end else begin
               sum = b;
               position = PosType;
            end
            return;
         end
         if (position < PosCheck) begin
            if (position == PosType) frame_kind = b;
            else if (position <= PosPayloadLast) payload[position - PosPayloadFirst] = b;
            sum = sum + b;
            position = position + 4'd1;
            return;
         end
         // checksum byte closes the frame
         case (frame_kind)
            TypeAccel: base = IdxAccelX;
            TypeGyro: base = IdxGyroX;
            TypeAngle: base = IdxRoll;
            default: base = -1;
         endcase
         if (base < 0) begin
            good = 2'd0;
         end else if (sum == b) begin
            for (int i = 0; i < 3; i++) held[base + i] = {payload[2*i+1], payload[2*i]};
            good = good + 2'd1;
         end
         position = PosHeader;
         frame_no = frame_no + 2'd1;
         if (frame_no >= FramesPerGroupDefault) begin
            hunting = 1'b1;
            frame_no = 2'd0;
            publish(good == FramesPerGroupDefault ? STATUS_GOOD : STATUS_INCOMPLETE);
         end
      endfunction

      function void check_word(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d actual %0d", name, $signed(want), $signed(got));
            errors++;
         end
      endfunction

      function void check_group(result_type got);
         result_type want;
         if (expected_groups.size() == 0) begin
            $error("result transfer with no group expected");
            errors++;
            return;
         end
         want = expected_groups.pop_front();
         check_word("accel_x", want.samples[IdxAccelX], got.samples[IdxAccelX]);
         check_word("accel_y", want.samples[IdxAccelY], got.samples[IdxAccelY]);
         check_word("accel_z", want.samples[IdxAccelZ], got.samples[IdxAccelZ]);
         check_word("gyro_x", want.samples[IdxGyroX], got.samples[IdxGyroX]);
         check_word("gyro_y", want.samples[IdxGyroY], got.samples[IdxGyroY]);
         check_word("gyro_z", want.samples[IdxGyroZ], got.samples[IdxGyroZ]);
         check_word("roll_angle", want.samples[IdxRoll], got.samples[IdxRoll]);
         check_word("pitch_angle", want.samples[IdxPitch], got.samples[IdxPitch]);
         check_word("yaw_angle", want.samples[IdxYaw], got.samples[IdxYaw]);
         check_word("group_status", 16'(want.status), 16'(got.status));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [7:0] req_data_byte;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [15:0] rsp_accel_x, rsp_accel_y, rsp_accel_z;
   logic signed [15:0] rsp_gyro_x, rsp_gyro_y, rsp_gyro_z;
   logic signed [15:0] rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle;
   logic [1:0] rsp_group_status;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   imu_group_tracker tracker = new();
   logic [7:0] link_header = HeaderByteReset;
   int sent_bytes = 0;
   bit sender_calm = 1'b0;

   always #10 clock = ~clock;

   imu_frame_group_parser i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_accel_x(rsp_accel_x),
      .rsp_accel_y(rsp_accel_y),
      .rsp_accel_z(rsp_accel_z),
      .rsp_gyro_x(rsp_gyro_x),
      .rsp_gyro_y(rsp_gyro_y),
      .rsp_gyro_z(rsp_gyro_z),
      .rsp_roll_angle(rsp_roll_angle),
      .rsp_pitch_angle(rsp_pitch_angle),
      .rsp_yaw_angle(rsp_yaw_angle),
      .rsp_group_status(rsp_group_status),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_kind();
      int r;
      logic [7:0] k;
      r = $urandom_range(0, 19);
      if (r < 6) return TypeAccel;
      if (r < 12) return TypeGyro;
      if (r < 18) return TypeAngle;
      do k = 8'($urandom); while (k == TypeAccel || k == TypeGyro || k == TypeAngle);
      return k;
   endfunction

   function automatic logic [7:0] pick_non_header();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == link_header) b = b ^ 8'h01;
      return b;
   endfunction

   // called just after a falling edge; returns just after a falling edge
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
      tracker.note_byte(b);
      sent_bytes++;
      if (sent_bytes % 200 == 0) sender_calm = ($urandom_range(0, 2) == 0);
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] first, input logic [7:0] kind,
                             input bit bad_sum, input logic [15:0] w0,
                             input logic [15:0] w1, input logic [15:0] w2);
      logic [7:0] body [10];
      logic [7:0] sum;
      body[0] = first;
      body[1] = kind;
      {body[3], body[2]} = w0;
      {body[5], body[4]} = w1;
      {body[7], body[6]} = w2;
      body[8] = 8'($urandom);
      body[9] = 8'($urandom);
      sum = 8'h00;
      for (int i = 0; i < 10; i++) begin
         sum = sum + body[i];
         send_byte(body[i]);
      end
      if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
      send_byte(sum);
   endtask

   task automatic send_random_frame();
      send_frame(link_header, pick_kind(), $urandom_range(0, 11) == 0,
                 pick_word(), pick_word(), pick_word());
   endtask

   task automatic write_header(input logic [7:0] value);
      req_valid <= 1'b0;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CsrAddrWidth'(4 * RegHeaderByte);
      csr_pwdata <= {24'h000000, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      tracker.header = value;
      link_header = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.expected_groups.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // result side: random stall with two long hold-offs
   initial begin
      int hold;
      int cycles;
      bit calm;
      hold = 0;
      cycles = 0;
      calm = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         cycles++;
         if (cycles % 400 == 0) calm = ($urandom_range(0, 2) == 0);
         if (cycles == 300 || cycles == 2500) hold = 150;
         else if (hold == 0) hold = pick_gap(calm);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : take_result
      result_type got;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.samples[IdxAccelX] = rsp_accel_x;
         got.samples[IdxAccelY] = rsp_accel_y;
         got.samples[IdxAccelZ] = rsp_accel_z;
         got.samples[IdxGyroX] = rsp_gyro_x;
         got.samples[IdxGyroY] = rsp_gyro_y;
         got.samples[IdxGyroZ] = rsp_gyro_z;
         got.samples[IdxRoll] = rsp_roll_angle;
         got.samples[IdxPitch] = rsp_pitch_angle;
         got.samples[IdxYaw] = rsp_yaw_angle;
         got.status = status_type'(rsp_group_status);
         tracker.check_group(got);
      end
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [7:0] settings [4];
      int start;
      int r;
      int lose_at;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = 32'h0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // noise while hunting, then header lost after a good accel frame
      send_byte(8'h00);
      send_byte(8'hff);
      send_frame(link_header, TypeAccel, 1'b0, 16'h7fff, 16'h8000, 16'hffff);
      send_byte(8'h00);
      // bad checksum on a gyro frame leaves the words alone, then header lost
      send_frame(link_header, TypeGyro, 1'b1, 16'h1234, 16'h8001, 16'h0001);
      send_byte(8'haa);

      settings[0] = 8'h00;
      settings[1] = 8'hff;
      settings[2] = 8'($urandom);
      settings[3] = HeaderByteReset;
      foreach (settings[p]) begin
         wait_drained();
         write_header(settings[p]);
         start = sent_bytes;
         while (sent_bytes - start < 350) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               repeat (FramesPerGroupDefault) send_random_frame();
            end else if (r < 85) begin
               lose_at = $urandom_range(1, FramesPerGroupDefault - 1);
               repeat (lose_at) send_random_frame();
               send_byte(pick_non_header());
            end else begin
               repeat ($urandom_range(1, 8))
                  send_byte($urandom_range(0, 9) == 0 ? 8'($urandom) : pick_non_header());
            end
         end
      end

      req_valid <= 1'b0;
      while (tracker.expected_groups.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (tracker.errors == 0 && tracker.expected_groups.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
